@@ rtl/rpq_pkg.sv @@
// Shared types and constants for the bitmap priority ready queue.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rpq_pkg;

	localparam int PRIO_LEVELS    = 16;
	localparam int MAX_TASK_COUNT = 32;
	localparam int LVL_W          = $clog2(PRIO_LEVELS);
	localparam int TASK_W         = $clog2(MAX_TASK_COUNT);

	typedef logic [TASK_W-1:0] task_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	typedef task_t [PRIO_LEVELS-1:0]    lvl_tasks_t;
	typedef task_t [MAX_TASK_COUNT-1:0] task_links_t;
	typedef lvl_t  [MAX_TASK_COUNT-1:0] task_lvls_t;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_RELOCATE = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_QUEUED     = 2'd1,
		ST_NOT_QUEUED = 2'd2
	} status_t;

	typedef struct packed {
		op_t   op;
		logic  tid_ok;
		task_t tid;
		lvl_t  lvl;
	} req_t;

	typedef struct packed {
		logic  valid;
		task_t tid;
	} head_t;

endpackage

`default_nettype wire

@@ rtl/rpq_head_enc.sv @@
// Priority encoder: head task of the lowest-numbered non-empty level.
// Depends on rpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpq_head_enc (
	input  wire logic [rpq_pkg::PRIO_LEVELS-1:0] nonempty,
	input  wire rpq_pkg::lvl_tasks_t             heads,
	output rpq_pkg::head_t                       head
);

	always_comb begin
		head = '0;
		for (int i = rpq_pkg::PRIO_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				head.valid = 1'b1;
				head.tid   = heads[i];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/rpq_state.sv @@
// Queue state: level bitmap, queued flags and per-level linked lists,
// with the single-pass unlink and tail-link update. Depends on rpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpq_state (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire rpq_pkg::req_t                   req,
	output logic [rpq_pkg::PRIO_LEVELS-1:0]      n_nonempty,
	output rpq_pkg::lvl_tasks_t                  n_head,
	output rpq_pkg::status_t                     status
);

	logic [rpq_pkg::PRIO_LEVELS-1:0]    nonempty_q;
	logic [rpq_pkg::MAX_TASK_COUNT-1:0] queued_q;
	rpq_pkg::lvl_tasks_t                head_q;
	rpq_pkg::lvl_tasks_t                tail_q;
	rpq_pkg::task_links_t               next_q;
	rpq_pkg::task_links_t               prev_q;
	rpq_pkg::task_lvls_t                lvl_q;

	logic [rpq_pkg::MAX_TASK_COUNT-1:0] n_queued;
	rpq_pkg::lvl_tasks_t                n_tail;
	rpq_pkg::task_links_t               n_next;
	rpq_pkg::task_links_t               n_prev;
	rpq_pkg::task_lvls_t                n_lvl;

	logic          do_unlink;
	logic          do_link;
	logic          is_head;
	logic          is_tail;
	rpq_pkg::lvl_t old_lvl;

	assign old_lvl = lvl_q[req.tid];
	assign is_head = (head_q[old_lvl] == req.tid);
	assign is_tail = (tail_q[old_lvl] == req.tid);

	always_comb begin
		status    = rpq_pkg::ST_OK;
		do_unlink = 1'b0;
		do_link   = 1'b0;
		if (req.op != rpq_pkg::OP_QUERY) begin
			if (!req.tid_ok) begin
				status = rpq_pkg::ST_NOT_QUEUED;
			end else if (req.op == rpq_pkg::OP_INSERT) begin
				if (queued_q[req.tid]) begin
					status = rpq_pkg::ST_QUEUED;
				end else begin
					do_link = 1'b1;
				end
			end else if (!queued_q[req.tid]) begin
				status = rpq_pkg::ST_NOT_QUEUED;
			end else begin
				do_unlink = 1'b1;
				do_link   = (req.op == rpq_pkg::OP_RELOCATE);
			end
		end
	end

	always_comb begin
		n_nonempty = nonempty_q;
		n_queued   = queued_q;
		n_head     = head_q;
		n_tail     = tail_q;
		n_next     = next_q;
		n_prev     = prev_q;
		n_lvl      = lvl_q;
		// unlink from the current level
		if (do_unlink) begin
			priority if (is_head && is_tail) begin
				n_nonempty[old_lvl] = 1'b0;
			end else if (is_head) begin
				n_head[old_lvl] = next_q[req.tid];
			end else if (is_tail) begin
				n_tail[old_lvl] = prev_q[req.tid];
			end else begin
				n_next[prev_q[req.tid]] = next_q[req.tid];
				n_prev[next_q[req.tid]] = prev_q[req.tid];
			end
			n_queued[req.tid] = 1'b0;
		end
		// append at the tail of the requested level
		if (do_link) begin
			if (n_nonempty[req.lvl]) begin
				n_next[n_tail[req.lvl]] = req.tid;
				n_prev[req.tid]         = n_tail[req.lvl];
				n_tail[req.lvl]         = req.tid;
			end else begin
				n_head[req.lvl]     = req.tid;
				n_tail[req.lvl]     = req.tid;
				n_nonempty[req.lvl] = 1'b1;
			end
			n_lvl[req.tid]    = req.lvl;
			n_queued[req.tid] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			queued_q   <= '0;
		end else if (en) begin
			nonempty_q <= n_nonempty;
			queued_q   <= n_queued;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_q <= n_head;
			tail_q <= n_tail;
			next_q <= n_next;
			prev_q <= n_prev;
			lvl_q  <= n_lvl;
		end
	end

endmodule

`default_nettype wire

@@ rtl/bitmap_priority_ready_queue.sv @@
// Bitmap priority ready queue: 16 FIFO levels of 32 task ids.
// Pipeline: a transaction is captured in the input register, then its result in the
// result register once that register is free. Throughput: one transaction per cycle
// while results are taken, set by the single-pass list update between the two registers.
// Reset: asynchronous; all levels empty, no task queued, both stages empty.
// Depends on rpq_pkg, rpq_state and rpq_head_enc.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_priority_ready_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [4:0] task_id,
	input  wire logic [3:0] priority_req,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic            head_valid,
	output logic [4:0]      head_task,
	output logic [1:0]      status
);

	logic                            valid_s1;
	rpq_pkg::req_t                   req_s1;
	rpq_pkg::req_t                   req_in;
	logic                            advance;
	logic                            res_valid_q;
	rpq_pkg::head_t                  head_q;
	rpq_pkg::status_t                status_q;
	rpq_pkg::status_t                n_status;
	logic [rpq_pkg::PRIO_LEVELS-1:0] n_nonempty;
	rpq_pkg::lvl_tasks_t             n_head;
	rpq_pkg::head_t                  n_head_sel;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || advance;

	always_comb begin
		req_in.op     = rpq_pkg::op_t'(opcode);
		req_in.tid_ok = (32'(task_id) < 32'(rpq_pkg::MAX_TASK_COUNT));
		req_in.tid    = rpq_pkg::TASK_W'(task_id);
		if (32'(priority_req) >= 32'(rpq_pkg::PRIO_LEVELS)) begin
			req_in.lvl = rpq_pkg::LVL_W'(rpq_pkg::PRIO_LEVELS - 1);
		end else begin
			req_in.lvl = rpq_pkg::LVL_W'(priority_req);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_in;
		end
	end

	rpq_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.req        (req_s1),
		.n_nonempty (n_nonempty),
		.n_head     (n_head),
		.status     (n_status)
	);

	rpq_head_enc u_head_enc (
		.nonempty (n_nonempty),
		.heads    (n_head),
		.head     (n_head_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			head_q   <= n_head_sel;
			status_q <= n_status;
		end
	end

	assign res_valid  = res_valid_q;
	assign head_valid = head_q.valid;
	assign head_task  = 5'(head_q.tid);
	assign status     = 2'(status_q);

endmodule

`default_nettype wire

@@ rtl/rpq_checker.sv @@
// Port-level checks for the bitmap priority ready queue, bound to the top level.
// Depends on rpq_pkg and bitmap_priority_ready_queue.
`timescale 1ns / 1ps
`default_nettype none

module rpq_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       head_valid,
	input wire logic [4:0] head_task,
	input wire logic [1:0] status
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(head_task)
			&& $stable(head_valid) && $stable(status))
		else $error("stalled result changed");

	// stall input only behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> res_valid && !res_ready)
		else $error("input stalled without output back-pressure");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !head_valid |-> head_task == 5'd0)
		else $error("head task set on empty queue");

	a_dup_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == 2'(rpq_pkg::ST_QUEUED) |-> head_valid)
		else $error("duplicate insert reported on empty queue");

endmodule

bind bitmap_priority_ready_queue rpq_checker u_rpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.head_valid (head_valid),
	.head_task  (head_task),
	.status     (status)
);

`default_nettype wire
